### rtl/gcd_pkg.sv
// Shared types and constants of the great-circle distance pipeline.
`timescale 1ns / 1ps
package gcd_pkg;

	// CORDIC iteration count and datapath widths
	localparam int STEPS = 32;
	localparam int XY_W  = 36;
	localparam int Z_W   = 34;

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0]  z_t;
	typedef logic [32:0]            q32_t;

	localparam q32_t ONE_Q32      = 33'h100000000;
	localparam z_t   QUARTER_TURN = 34'sh040000000;
	localparam z_t   HALF_TURN    = 34'sh080000000;
	localparam xy_t  CORDIC_GAIN  = 36'sh09B74EDA8;

	// fractional part of 2^64 / (360 degrees in 1e-7 units)
	localparam logic [29:0] TURN_GAIN_LOW = 30'h316B7E58;

	// floor(pi * 2^32) * 4 * 6371000, split into high and low parts
	localparam logic [63:0] DIST_FACTOR = 64'd343856572848736000;
	localparam logic [26:0] DIST_FH     = DIST_FACTOR[58:32];
	localparam logic [31:0] DIST_FL     = DIST_FACTOR[31:0];
	localparam logic [24:0] DIST_MAX    = 25'd20015087;

	// arctan(2^-i) in binary angle units
	localparam logic [31:0] ATAN_TAB [STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

endpackage

### rtl/gcd_cordic.sv
// Pipelined CORDIC, one iteration per stage, rotation or vectoring mode.
`timescale 1ns / 1ps
module gcd_cordic #(
	parameter bit VECTOR = 1'b0,
	parameter int LANES  = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  gcd_pkg::xy_t    in_x [LANES],
	input  gcd_pkg::xy_t    in_y [LANES],
	input  gcd_pkg::z_t     in_z [LANES],
	output logic            out_valid,
	output gcd_pkg::xy_t    out_x [LANES],
	output gcd_pkg::xy_t    out_y [LANES],
	output gcd_pkg::z_t     out_z [LANES]
);
	import gcd_pkg::*;

	logic vld_s [0:STEPS];
	xy_t  x_s   [0:STEPS][LANES];
	xy_t  y_s   [0:STEPS][LANES];
	z_t   z_s   [0:STEPS][LANES];

	assign vld_s[0] = in_valid;

	// advance the valid bit with the data
	for (genvar i = 0; i < STEPS; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign x_s[0][l] = in_x[l];
		assign y_s[0][l] = in_y[l];
		assign z_s[0][l] = in_z[l];

		// one micro-rotation per stage
		for (genvar i = 0; i < STEPS; i++) begin : g_step
			localparam z_t ANG = z_t'({2'b00, ATAN_TAB[i]});
			logic sub;
			xy_t  xs, ys;

			always_comb begin
				xs  = x_s[i][l] >>> i;
				ys  = y_s[i][l] >>> i;
				sub = VECTOR ? (y_s[i][l] <= 0) : (z_s[i][l] >= 0);
			end

			always_ff @(posedge clk) begin
				if (sub) begin
					x_s[i+1][l] <= x_s[i][l] - ys;
					y_s[i+1][l] <= y_s[i][l] + xs;
					z_s[i+1][l] <= z_s[i][l] - ANG;
				end else begin
					x_s[i+1][l] <= x_s[i][l] + ys;
					y_s[i+1][l] <= y_s[i][l] - xs;
					z_s[i+1][l] <= z_s[i][l] + ANG;
				end
			end
		end

		assign out_x[l] = x_s[STEPS][l];
		assign out_y[l] = y_s[STEPS][l];
		assign out_z[l] = z_s[STEPS][l];
	end

	assign out_valid = vld_s[STEPS];

endmodule

### rtl/gcd_sqrt.sv
// Two-lane pipelined Q32 square root, one result bit per stage.
`timescale 1ns / 1ps
module gcd_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  gcd_pkg::q32_t in_a,
	input  gcd_pkg::q32_t in_b,
	output logic          out_valid,
	output gcd_pkg::q32_t root_a,
	output gcd_pkg::q32_t root_b
);
	import gcd_pkg::*;

	localparam int SQ_STEPS = 32;

	logic        vld_s [0:SQ_STEPS];
	logic [63:0] v_s   [0:SQ_STEPS][2];
	logic [63:0] res_s [0:SQ_STEPS][2];
	logic        one_s [0:SQ_STEPS][2];
	q32_t        x_in  [2];
	q32_t        root  [2];

	assign vld_s[0] = in_valid;
	assign x_in[0]  = in_a;
	assign x_in[1]  = in_b;

	// advance the valid bit with the data
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		// an operand of 1.0 or more gives exactly 1.0
		assign one_s[0][l] = x_in[l][32];
		assign v_s[0][l]   = {x_in[l][31:0], 32'h0};
		assign res_s[0][l] = 64'h0;

		for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
			localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
			logic [63:0] cand;
			logic        ge;

			always_comb begin
				cand = res_s[k][l] + BIT;
				ge   = v_s[k][l] >= cand;
			end

			always_ff @(posedge clk) begin
				one_s[k+1][l] <= one_s[k][l];
				if (ge) begin
					v_s[k+1][l]   <= v_s[k][l] - cand;
					res_s[k+1][l] <= (res_s[k][l] >> 1) + BIT;
				end else begin
					v_s[k+1][l]   <= v_s[k][l];
					res_s[k+1][l] <= res_s[k][l] >> 1;
				end
			end
		end

		assign root[l] = one_s[SQ_STEPS][l] ? ONE_Q32 : res_s[SQ_STEPS][l][32:0];
	end

	assign out_valid = vld_s[SQ_STEPS];
	assign root_a    = root[0];
	assign root_b    = root[1];

endmodule

### rtl/great_circle_distance.sv
// Top level of the haversine great-circle distance pipeline.
// Usage:
//   Drive the two points on the coordinate ports and raise start; a beat is
//   taken at every rising edge with start high and busy low. busy stays low:
//   the pipeline takes a new point pair in every cycle.
//   Each distance appears on distance_metres for one cycle with done high,
//   in the order the beats came in.
//   Stages: 4 angle stages, 32 sine/cosine CORDIC stages, 6 product stages,
//   32 square-root stages, 32 arctangent CORDIC stages, 3 scaling stages.
//   Throughput: one point pair per cycle, set by the fully unrolled CORDIC
//   and square-root pipelines.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset clears all valid bits, so nothing is reported until new beats
//   have passed through; the datapath registers are not reset.
`timescale 1ns / 1ps
module great_circle_distance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	output logic               done,
	output logic [24:0]        distance_metres
);
	import gcd_pkg::*;

	// lanes: 0 latitude difference, 1 longitude difference, 2 and 3 latitudes
	logic        acc;
	logic signed [33:0] d_in [4];

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] m_s1 [4];
	logic        neg_s1 [4];
	logic [31:0] m_s2 [4];
	logic        neg_s2 [4];
	logic [61:0] p_s2 [4];
	logic [31:0] ang_s3 [4];
	z_t          z_s4 [4];
	logic        flip_s4 [4];

	xy_t  cx_in [4];
	xy_t  cy_in [4];
	logic cv_out;
	xy_t  cx_out [4];
	xy_t  cy_out [4];
	z_t   cz_out [4];
	logic [3:0] flip_d [0:STEPS];

	logic v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	q32_t mag_s5 [4];
	logic cdiff_s5;
	logic [49:0] hi_s6 [3];
	logic [48:0] lo_s6 [3];
	logic cdiff_s6;
	q32_t sl2_s7, so2_s7, cc_s7;
	logic cdiff_s7;
	logic [49:0] thi_s8;
	logic [48:0] tlo_s8;
	q32_t sl2_s8;
	logic cdiff_s8;
	q32_t term_s9, sl2_s9;
	logic cdiff_s9;
	q32_t a_s10, oma_s10;

	logic sv_out;
	q32_t ry, rx;
	xy_t  ax_in [1];
	xy_t  ay_in [1];
	z_t   az_in [1];
	logic av_out;
	xy_t  ax_out [1];
	xy_t  ay_out [1];
	z_t   az_out [1];

	logic v_s11, v_s12, v_s13;
	logic [57:0] phi_s11;
	logic [62:0] plo_s11;
	logic [26:0] d_s12;
	logic [24:0] dist_s13;

	// magnitude of a CORDIC output, limited to 1.0
	function automatic q32_t mag_lim(input xy_t v);
		xy_t a;
		a = v[XY_W-1] ? -v : v;
		if (a > xy_t'(ONE_Q32)) begin
			return ONE_Q32;
		end
		return a[32:0];
	endfunction

	// finish a Q32 product from its split partial products
	function automatic q32_t q_fin(input logic [49:0] hi, input logic [48:0] lo);
		logic [50:0] t;
		t = 51'(hi) + 51'(lo[48:16]) + 51'h8000;
		return t[48:16];
	endfunction

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	assign d_in[0] = 34'(second_latitude) - 34'(first_latitude);
	assign d_in[1] = 34'(second_longitude) - 34'(first_longitude);
	assign d_in[2] = 34'(first_latitude) <<< 1;
	assign d_in[3] = 34'(second_latitude) <<< 1;

	// hold valid bits of the angle, product and scaling stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			v_s1  <= acc;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= cv_out;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= av_out;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// convert coordinate values to half binary angles
	for (genvar l = 0; l < 4; l++) begin : g_ang
		logic signed [33:0] mag;
		logic [64:0]        sum;
		z_t                 zs;

		always_comb begin
			mag = d_in[l][33] ? -d_in[l] : d_in[l];
			sum = {2'b00, m_s2[l], 31'h0} + {4'h0, p_s2[l][61:1]} + 65'h80000000;
			zs  = z_t'(signed'(ang_s3[l]));
		end

		always_ff @(posedge clk) begin
			m_s1[l]   <= mag[31:0];
			neg_s1[l] <= d_in[l][33];
			m_s2[l]   <= m_s1[l];
			neg_s2[l] <= neg_s1[l];
			p_s2[l]   <= 62'(m_s1[l]) * 62'(TURN_GAIN_LOW);
			ang_s3[l] <= neg_s2[l] ? 32'(-sum[63:32]) : sum[63:32];
			// fold the angle into the right half plane
			if (zs > QUARTER_TURN) begin
				z_s4[l]    <= zs - HALF_TURN;
				flip_s4[l] <= 1'b1;
			end else if (zs < -QUARTER_TURN) begin
				z_s4[l]    <= zs + HALF_TURN;
				flip_s4[l] <= 1'b1;
			end else begin
				z_s4[l]    <= zs;
				flip_s4[l] <= 1'b0;
			end
		end

		assign cx_in[l]    = CORDIC_GAIN;
		assign cy_in[l]    = '0;
		assign flip_d[0][l] = flip_s4[l];
	end

	gcd_cordic #(
		.VECTOR (1'b0),
		.LANES  (4)
	) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_x      (cx_in),
		.in_y      (cy_in),
		.in_z      (z_s4),
		.out_valid (cv_out),
		.out_x     (cx_out),
		.out_y     (cy_out),
		.out_z     (cz_out)
	);

	// delay the fold flags alongside the CORDIC
	for (genvar i = 0; i < STEPS; i++) begin : g_flip
		always_ff @(posedge clk) begin
			flip_d[i+1] <= flip_d[i];
		end
	end

	// form magnitudes and the sign relation of the two latitude cosines
	always_ff @(posedge clk) begin
		logic n1, n2;
		n1 = flip_d[STEPS][2] ? (cx_out[2] > 0) : (cx_out[2] < 0);
		n2 = flip_d[STEPS][3] ? (cx_out[3] > 0) : (cx_out[3] < 0);
		mag_s5[0] <= mag_lim(cy_out[0]);
		mag_s5[1] <= mag_lim(cy_out[1]);
		mag_s5[2] <= mag_lim(cx_out[2]);
		mag_s5[3] <= mag_lim(cx_out[3]);
		cdiff_s5  <= n1 ^ n2;
	end

	// square the sines, multiply the cosines and weight that product by the longitude term
	always_ff @(posedge clk) begin
		hi_s6[0] <= 50'(mag_s5[0][32:16]) * 50'(mag_s5[0]);
		lo_s6[0] <= 49'(mag_s5[0][15:0]) * 49'(mag_s5[0]);
		hi_s6[1] <= 50'(mag_s5[1][32:16]) * 50'(mag_s5[1]);
		lo_s6[1] <= 49'(mag_s5[1][15:0]) * 49'(mag_s5[1]);
		hi_s6[2] <= 50'(mag_s5[2][32:16]) * 50'(mag_s5[3]);
		lo_s6[2] <= 49'(mag_s5[2][15:0]) * 49'(mag_s5[3]);
		cdiff_s6 <= cdiff_s5;

		sl2_s7   <= q_fin(hi_s6[0], lo_s6[0]);
		so2_s7   <= q_fin(hi_s6[1], lo_s6[1]);
		cc_s7    <= q_fin(hi_s6[2], lo_s6[2]);
		cdiff_s7 <= cdiff_s6;

		thi_s8   <= 50'(cc_s7[32:16]) * 50'(so2_s7);
		tlo_s8   <= 49'(cc_s7[15:0]) * 49'(so2_s7);
		sl2_s8   <= sl2_s7;
		cdiff_s8 <= cdiff_s7;

		term_s9  <= q_fin(thi_s8, tlo_s8);
		sl2_s9   <= sl2_s8;
		cdiff_s9 <= cdiff_s8;
	end

	// combine into a, clamp to [0, 1.0] and form 1 - a
	always_ff @(posedge clk) begin
		logic signed [34:0] sa;
		q32_t ac;
		if (cdiff_s9) begin
			sa = signed'({2'b00, sl2_s9}) - signed'({2'b00, term_s9});
		end else begin
			sa = signed'({2'b00, sl2_s9}) + signed'({2'b00, term_s9});
		end
		if (sa < 0) begin
			ac = '0;
		end else if (sa > 35'(ONE_Q32)) begin
			ac = ONE_Q32;
		end else begin
			ac = sa[32:0];
		end
		a_s10   <= ac;
		oma_s10 <= ONE_Q32 - ac;
	end

	gcd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s10),
		.in_a      (a_s10),
		.in_b      (oma_s10),
		.out_valid (sv_out),
		.root_a    (ry),
		.root_b    (rx)
	);

	assign ax_in[0] = xy_t'(rx);
	assign ay_in[0] = xy_t'(ry);
	assign az_in[0] = '0;

	gcd_cordic #(
		.VECTOR (1'b1),
		.LANES  (1)
	) u_atan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sv_out),
		.in_x      (ax_in),
		.in_y      (ay_in),
		.in_z      (az_in),
		.out_valid (av_out),
		.out_x     (ax_out),
		.out_y     (ay_out),
		.out_z     (az_out)
	);

	// clamp the central angle and scale to metres
	always_ff @(posedge clk) begin
		z_t          zc;
		logic [58:0] dq;
		if (az_out[0] < 0) begin
			zc = '0;
		end else if (az_out[0] > QUARTER_TURN) begin
			zc = QUARTER_TURN;
		end else begin
			zc = az_out[0];
		end
		phi_s11 <= 58'(zc[30:0]) * 58'(DIST_FH);
		plo_s11 <= 63'(zc[30:0]) * 63'(DIST_FL);

		dq    = 59'(phi_s11) + 59'(plo_s11[62:32]) + 59'h80000000;
		d_s12 <= dq[58:32];

		dist_s13 <= (d_s12 > 27'(DIST_MAX)) ? DIST_MAX : d_s12[24:0];
	end

	assign done            = v_s13;
	assign distance_metres = dist_s13;

endmodule

### dv/gcd_checker.sv
// Checker for the great-circle distance block: predicts each distance and compares.
`timescale 1ns / 1ps
module gcd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	input  logic               done,
	input  logic [24:0]        distance_metres,
	output int                 fail_count,
	output int                 pending,
	output int                 beats_in,
	output int                 beats_out
);
	import gcd_pkg::*;

	localparam longint ONE = 64'sh100000000;
	localparam longint QTR = 64'sh40000000;

	logic [24:0] distance_queue [$];

	// binary angle of half the coordinate difference
	function automatic logic [31:0] half_turn_angle(longint d7);
		logic [63:0] m, p, r;
		logic        neg;
		neg = d7 < 0;
		m = neg ? -d7 : d7;
		m = m & 64'hFFFFFFFF;
		p = m * {34'd0, TURN_GAIN_LOW};
		r = ((m << 31) + (p >> 1) + 64'h80000000) >> 32;
		return neg ? 32'(0 - r[31:0]) : r[31:0];
	endfunction

	// rotation CORDIC after folding into the right half plane
	function automatic void rotate(input logic [31:0] ang, output longint c,
			output longint s);
		longint z, x, y, nx;
		logic   flip;
		z = {32'd0, ang};
		x = 64'sh9B74EDA8;
		y = 0;
		flip = 0;
		if (z >= 64'sh80000000) z -= ONE;
		if (z > QTR) begin
			z -= 2 * QTR;
			flip = 1;
		end else if (z < -QTR) begin
			z += 2 * QTR;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint clamp_mag(longint v);
		longint m;
		m = v < 0 ? -v : v;
		return m > ONE ? ONE : m;
	endfunction

	function automatic longint q32_product(longint a, longint b);
		longint t;
		t = (a >> 16) * b + (((a & 64'hFFFF) * b) >> 16);
		return (t + 64'h8000) >> 16;
	endfunction

	function automatic longint q32_root(longint x);
		logic [63:0] v, res, bt;
		if (x >= ONE) return ONE;
		v = x << 32;
		res = 0;
		bt = 64'h1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint arc_angle(longint x, longint y);
		longint z, nx;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > QTR) z = QTR;
		return z;
	endfunction

	function automatic logic [24:0] predict_distance(longint lat1, longint lon1,
			longint lat2, longint lon2);
		longint      c1, s1, c2, s2, cdl, sdl, cdo, sdo, a, z;
		longint      sl2, so2, cc, term, ry, rx;
		logic [63:0] dq, d;
		rotate(half_turn_angle(lat2 - lat1), cdl, sdl);
		rotate(half_turn_angle(lon2 - lon1), cdo, sdo);
		rotate(half_turn_angle(2 * lat1), c1, s1);
		rotate(half_turn_angle(2 * lat2), c2, s2);
		sl2 = q32_product(clamp_mag(sdl), clamp_mag(sdl));
		so2 = q32_product(clamp_mag(sdo), clamp_mag(sdo));
		cc = q32_product(clamp_mag(c1), clamp_mag(c2));
		term = q32_product(cc, so2);
		a = ((c1 < 0) != (c2 < 0)) ? sl2 - term : sl2 + term;
		if (a < 0) a = 0;
		if (a > ONE) a = ONE;
		ry = q32_root(a);
		rx = q32_root(ONE - a);
		z = arc_angle(rx, ry);
		dq = z * {37'd0, DIST_FH} + ((z * {32'd0, DIST_FL}) >> 32);
		d = (dq + 64'h80000000) >> 32;
		if (d > {39'd0, DIST_MAX}) d = {39'd0, DIST_MAX};
		return d[24:0];
	endfunction

	assign pending = distance_queue.size();

	// predict on each accepted beat, compare each done beat
	always @(posedge clk or negedge arst_n) begin
		logic [24:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			beats_in <= 0;
			beats_out <= 0;
		end else begin
			if (start && !busy) begin
				distance_queue.push_back(predict_distance(first_latitude, first_longitude,
					second_latitude, second_longitude));
				beats_in <= beats_in + 1;
			end
			if (done) begin
				beats_out <= beats_out + 1;
				if (distance_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected distance %0d", distance_metres);
					fail_count <= fail_count + 1;
				end else begin
					want = distance_queue.pop_front();
					if (want !== distance_metres) begin
						if (fail_count < 10)
							$display("distance mismatch: expected %0d got %0d", want,
								distance_metres);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

### dv/testbench.sv
// Top of the great-circle distance testbench: stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic signed [30:0] first_latitude = 0;
	logic signed [31:0] first_longitude = 0;
	logic signed [30:0] second_latitude = 0;
	logic signed [31:0] second_longitude = 0;
	logic               done;
	logic [24:0]        distance_metres;
	int                 fail_count, pending, beats_in, beats_out;

	localparam int LAT_MAX = 900000000;
	localparam int LON_MAX = 1800000000;

	always #2 clk = ~clk;

	great_circle_distance dut (.*);
	gcd_checker checker_i (.*);

	// drive one beat, hold until taken
	task automatic send_pair(int lat1, int lon1, int lat2, int lon2);
		first_latitude <= lat1[30:0];
		first_longitude <= lon1;
		second_latitude <= lat2[30:0];
		second_longitude <= lon2;
		start <= 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic idle_burst();
		start <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	function automatic int pick_lat();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
			1: return $urandom;
			2: return 0;
			default: return $signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
		endcase
	endfunction

	function automatic int pick_lon();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? LON_MAX : -LON_MAX;
			1: return $urandom;
			default: return $signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
		endcase
	endfunction

	initial begin
		int lat, lon;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// corners: same point, poles, antipodes, date line, out-of-range wrap
		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		send_pair(-LAT_MAX, 123, -LAT_MAX, -LON_MAX);
		send_pair(0, 900000000, 0, -900000000);
		send_pair(450000000, 0, -450000000, LON_MAX);
		send_pair(1, 1, 0, 0);
		send_pair(-1, -1, 0, 0);
		send_pair(32'h3FFFFFFF, 32'h7FFFFFFF, 32'hC0000000, 32'h80000000);
		send_pair(32'hC0000000, 32'h80000000, 32'h3FFFFFFF, 32'h7FFFFFFF);
		send_pair(515000000, -1200000, 407000000, -740000000);
		send_pair(123456789, 987654321, 123456790, 987654322);
		start <= 0;
		// hold off until the pipeline has drained
		wait (pending == 0);
		@(negedge clk);
		for (int i = 0; i < 1500; i++) begin
			if (i < 1300 && $urandom_range(0, 7) == 0) idle_burst();
			lat = pick_lat();
			lon = pick_lon();
			// half nearby pairs, half independent
			if ($urandom_range(0, 1))
				send_pair(lat, lon, lat + $signed($urandom_range(0, 2000000)) - 1000000,
					lon + $signed($urandom_range(0, 2000000)) - 1000000);
			else
				send_pair(lat, lon, pick_lat(), pick_lon());
		end
		start <= 0;
		wait (pending == 0);
		repeat (150) @(negedge clk);
		$display("Sent %0d point pairs, checked %0d distances (poles, date line, antipodes,",
			beats_in, beats_out);
		$display("wrapped coordinates, nearby and random pairs).");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#200000;
		$display("Timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
